>>> hw/rtl/clsq_pkg.sv
package clsq_pkg;

   // request kinds carried on req_tuser
   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_INIT      = 3'd1;
   localparam logic [2:0] OP_CHAR      = 3'd2;
   localparam logic [2:0] OP_COMMAND   = 3'd3;
   localparam logic [2:0] OP_CURSOR    = 3'd4;
   localparam logic [2:0] OP_CMODE     = 3'd5;
   localparam logic [2:0] OP_SAMPLE    = 3'd6;

   // bus access kinds carried on rsp_tuser
   localparam logic [1:0] ACC_READ     = 2'd0;
   localparam logic [1:0] ACC_CMD      = 2'd1;
   localparam logic [1:0] ACC_DATA     = 2'd2;

   // sequencer phases
   localparam logic [4:0] PH_IDLE       = 5'd0;
   localparam logic [4:0] PH_WAIT_FIRST = 5'd1;
   localparam logic [4:0] PH_WAIT_MID   = 5'd2;
   localparam logic [4:0] PH_WAIT_LAST  = 5'd3;
   localparam logic [4:0] PH_POLL_FIRST = 5'd4;
   localparam logic [4:0] PH_DC         = 5'd8;
   localparam logic [4:0] PH_POLL_LAST  = 5'd12;
   localparam logic [4:0] PH_QUEUE      = 5'd13;

   // fixed bytes and delays
   localparam logic [7:0] BYTE_WAKE     = 8'h30;
   localparam logic [7:0] DC_DEFAULT    = 8'h0C;
   localparam logic [7:0] DC_UNDERLINE  = 8'h0E;
   localparam logic [7:0] DC_BLINK      = 8'h0F;
   localparam logic [7:0] TIMEOUT_RESET = 8'd20;
   localparam logic [7:0] DELAY_POWERUP = 8'd15;
   localparam logic [7:0] DELAY_SECOND  = 8'd5;
   localparam logic [7:0] DELAY_THIRD   = 8'd2;

   // one result on the output channel
   typedef struct packed {
      logic [1:0] access;
      logic [7:0] bus_byte;
      logic       last;
      logic       reinit_needed;
      logic       ready_res;
   } rsp_entry_type;

   // results produced by one input transaction
   typedef struct packed {
      logic [1:0]    count;
      rsp_entry_type e0;
      rsp_entry_type e1;
   } rsp_push_type;

   // polled part of the power-up script: {access, byte}
   function automatic logic [9:0] init_script(input logic [3:0] idx);
      logic [9:0] r;
      case (idx)
         4'd0:    r = {ACC_CMD, 8'h38};
         4'd1:    r = {ACC_CMD, 8'h38};
         4'd2:    r = {ACC_CMD, 8'h01};
         4'd3:    r = {ACC_CMD, 8'h06};
         4'd4:    r = {ACC_CMD, 8'h0C};
         4'd5:    r = {ACC_CMD, 8'h94};
         4'd6:    r = {ACC_DATA, 8'h20};
         4'd7:    r = {ACC_CMD, 8'hD4};
         4'd8:    r = {ACC_DATA, 8'h20};
         default: r = {ACC_CMD, 8'h38};
      endcase
      return r;
   endfunction

   // map a cursor position to a set-DDRAM-address command
   function automatic logic [7:0] cursor_address(input logic [7:0] pos);
      logic [7:0] p;
      p = pos;
      if (p > 8'd15) begin
         p = (p & 8'h2F) | 8'h40;
      end
      return p | 8'h80;
   endfunction

endpackage

>>> hw/rtl/char_lcd_bus_sequencer.sv
// Host-side sequencer for a character LCD on an 8-bit bus. Each input transaction
// (tick, request or sampled status byte) is handled in the cycle it is accepted and
// yields zero, one or two bus accesses, which go into a small output queue
// (RSP_DEPTH entries). A transaction is accepted every cycle as long as the queue has
// room for two results; the result channel moves one access per cycle while rsp_tready
// is high, so items that produce two accesses outrun it, all others keep one per cycle.
// Requests that arrive while a sequence is running, stray ticks and samples, and the
// unused kind code are dropped without result. The csr channel writes busy_timeout
// (0 is taken as 1) and is always ready; write it only while the block is idle.
module char_lcd_bus_sequencer
   import clsq_pkg::*;
#(
   parameter int RSP_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] value, [15:8] port_data
   input  logic [2:0]  req_tuser,   // [2:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] bus_byte, [8] reinit_needed, [9] ready_res
   output logic [1:0]  rsp_tuser,   // [1:0] access
   output logic        rsp_tlast,   // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   logic [7:0] timeout_ff, timeout_in;
   logic [4:0] phase_ff, phase_in;
   logic [7:0] timer_ff, timer_in;
   logic [5:0] cursor_ff, cursor_in;
   logic [7:0] dc_ff, dc_in;
   logic [9:0] pend_ff [3];
   logic [9:0] pend_in [3];
   logic [1:0] pcnt_ff, pcnt_in;
   logic       reinit_ff, reinit_in;

   logic          accept;
   logic [2:0]    op;
   logic [7:0]    val;
   logic [7:0]    port;
   logic [1:0]    n_res;
   logic [1:0]    res_acc [2];
   logic [7:0]    res_byte [2];
   logic [9:0]    script_e;
   logic [4:0]    phase_up;
   logic          timed_out;
   logic          do_finish;
   rsp_push_type  push;
   rsp_entry_type head;
   logic          space_two;

   assign op        = req_tuser;
   assign val       = req_tdata[7:0];
   assign port      = req_tdata[15:8];
   assign accept    = req_tvalid && req_tready;
   assign req_tready = space_two;
   assign csr_ready = 1'b1;
   assign script_e  = init_script(4'(phase_ff - PH_POLL_FIRST));
   assign phase_up  = phase_ff + 5'd1;

   // configuration write
   always_comb begin
      timeout_in = timeout_ff;
      if (csr_valid) begin
         timeout_in = (csr_data == 8'd0) ? 8'd1 : csr_data;
      end
   end

   // one-pass state update and result generation
   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      cursor_in = cursor_ff;
      dc_in     = dc_ff;
      pend_in   = pend_ff;
      pcnt_in   = pcnt_ff;
      reinit_in = reinit_ff;
      n_res     = 2'd0;
      res_acc   = '{ACC_READ, ACC_READ};
      res_byte  = '{8'd0, 8'd0};
      timed_out = 1'b0;
      do_finish = 1'b0;

      if (accept) begin
         case (op)
            OP_TICK: begin
               if (phase_ff >= PH_WAIT_FIRST && phase_ff <= PH_WAIT_LAST) begin
                  if (timer_ff <= 8'd1) begin
                     res_acc[0]  = ACC_CMD;
                     res_byte[0] = BYTE_WAKE;
                     n_res       = 2'd1;
                     if (phase_ff < PH_WAIT_LAST) begin
                        phase_in = phase_up;
                        timer_in = (phase_up == PH_WAIT_MID) ? DELAY_SECOND : DELAY_THIRD;
                     end else begin
                        phase_in    = PH_POLL_FIRST;
                        timer_in    = timeout_ff;
                        res_acc[1]  = ACC_READ;
                        res_byte[1] = 8'd0;
                        n_res       = 2'd2;
                     end
                  end else begin
                     timer_in = timer_ff - 8'd1;
                  end
               end else if (phase_ff != PH_IDLE) begin
                  if (timer_ff <= 8'd1) begin
                     do_finish = 1'b1;
                     timed_out = 1'b1;
                  end else begin
                     timer_in = timer_ff - 8'd1;
                  end
               end
            end
            OP_SAMPLE: begin
               if (phase_ff >= PH_POLL_FIRST && phase_ff <= PH_QUEUE) begin
                  if (!port[7]) begin
                     do_finish = 1'b1;
                  end else begin
                     res_acc[0]  = ACC_READ;
                     res_byte[0] = 8'd0;
                     n_res       = 2'd1;
                  end
               end
            end
            OP_INIT, OP_CHAR, OP_COMMAND, OP_CURSOR, OP_CMODE: begin
               if (phase_ff == PH_IDLE) begin
                  if (op == OP_INIT) begin
                     phase_in = PH_WAIT_FIRST;
                     timer_in = DELAY_POWERUP;
                     pcnt_in  = 2'd0;
                  end else begin
                     case (op)
                        OP_CHAR: begin
                           cursor_in  = cursor_ff + 6'd1;
                           pend_in[0] = {ACC_DATA, val};
                           pend_in[1] = {ACC_CMD, cursor_address({2'b00, cursor_in})};
                           pend_in[2] = {ACC_CMD, dc_ff};
                           pcnt_in    = 2'd3;
                        end
                        OP_COMMAND: begin
                           pend_in[0] = {ACC_CMD, val};
                           pcnt_in    = 2'd1;
                        end
                        OP_CURSOR: begin
                           cursor_in  = val[5:0];
                           pend_in[0] = {ACC_CMD, cursor_address(val)};
                           pend_in[1] = {ACC_CMD, dc_ff};
                           pcnt_in    = 2'd2;
                        end
                        default: begin
                           if (val == 8'd0) begin
                              dc_in = DC_DEFAULT;
                           end else if (val == 8'd2) begin
                              dc_in = DC_UNDERLINE;
                           end else begin
                              dc_in = DC_BLINK;
                           end
                           pend_in[0] = {ACC_CMD, dc_in};
                           pcnt_in    = 2'd1;
                        end
                     endcase
                     phase_in    = PH_QUEUE;
                     timer_in    = timeout_ff;
                     res_acc[0]  = ACC_READ;
                     res_byte[0] = 8'd0;
                     n_res       = 2'd1;
                  end
               end
            end
            default: begin
            end
         endcase

         // end of a busy poll: issue the waiting write, then poll again if more follow
         if (do_finish) begin
            if (timed_out) begin
               reinit_in = 1'b1;
            end
            if (phase_ff >= PH_POLL_FIRST && phase_ff <= PH_POLL_LAST) begin
               res_acc[0]  = script_e[9:8];
               res_byte[0] = script_e[7:0];
               n_res       = 2'd1;
               if (phase_ff == PH_DC) begin
                  dc_in     = DC_DEFAULT;
                  cursor_in = 6'd0;
                  reinit_in = 1'b0;
               end
               if (phase_ff == PH_POLL_LAST) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in    = phase_up;
                  timer_in    = timeout_ff;
                  res_acc[1]  = ACC_READ;
                  res_byte[1] = 8'd0;
                  n_res       = 2'd2;
               end
            end else if (phase_ff == PH_QUEUE) begin
               res_acc[0]  = pend_ff[0][9:8];
               res_byte[0] = pend_ff[0][7:0];
               n_res       = 2'd1;
               pend_in[0]  = pend_ff[1];
               pend_in[1]  = pend_ff[2];
               pcnt_in     = (pcnt_ff != 2'd0) ? pcnt_ff - 2'd1 : 2'd0;
               if (pcnt_in != 2'd0) begin
                  timer_in    = timeout_ff;
                  res_acc[1]  = ACC_READ;
                  res_byte[1] = 8'd0;
                  n_res       = 2'd2;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
      end
   end

   // pack results for the output queue
   always_comb begin
      push.count            = n_res;
      push.e0.access        = res_acc[0];
      push.e0.bus_byte      = res_byte[0];
      push.e0.last          = (n_res == 2'd1);
      push.e0.reinit_needed = reinit_in;
      push.e0.ready_res     = (phase_in == PH_IDLE);
      push.e1.access        = res_acc[1];
      push.e1.bus_byte      = res_byte[1];
      push.e1.last          = 1'b1;
      push.e1.reinit_needed = reinit_in;
      push.e1.ready_res     = (phase_in == PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         phase_ff   <= PH_IDLE;
         timer_ff   <= 8'd0;
         cursor_ff  <= 6'd0;
         dc_ff      <= DC_DEFAULT;
         pcnt_ff    <= 2'd0;
         reinit_ff  <= 1'b0;
      end else begin
         timeout_ff <= timeout_in;
         phase_ff   <= phase_in;
         timer_ff   <= timer_in;
         cursor_ff  <= cursor_in;
         dc_ff      <= dc_in;
         pcnt_ff    <= pcnt_in;
         reinit_ff  <= reinit_in;
      end
   end

   // queued writes of a request: payload only
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

   clsq_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_two (space_two),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_entry (head)
   );

   assign rsp_tuser = head.access;
   assign rsp_tlast = head.last;
   assign rsp_tdata = {6'd0, head.ready_res, head.reinit_needed, head.bus_byte};

endmodule

>>> hw/rtl/clsq_rsp_fifo.sv
module clsq_rsp_fifo
   import clsq_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  rsp_push_type  push,
   output logic          space_two,
   output logic          out_valid,
   input  logic          out_ready,
   output rsp_entry_type out_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic             pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign wr_ptr_next = ptr_inc(wr_ptr_ff);
   assign pop         = out_valid && out_ready;
   assign out_valid   = (cnt_ff != '0);
   assign out_entry   = mem_ff[rd_ptr_ff];
   assign space_two   = (cnt_ff <= CNT_W'(DEPTH - 2));

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.count == 2'd1) begin
         wr_ptr_in = wr_ptr_next;
      end else if (push.count == 2'd2) begin
         wr_ptr_in = ptr_inc(wr_ptr_next);
      end
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // store up to two results per cycle
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.e0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.e1;
      end
   end

endmodule

>>> verif/char_lcd_bus_sequencer_tb.sv
`timescale 1ns / 100ps

module char_lcd_bus_sequencer_tb;
   import clsq_pkg::*;

   // kind code the block has no use for
   localparam logic [2:0] OP_UNUSED = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [7:0] value, [15:8] port_data
   logic [2:0]  req_tuser = OP_TICK; // [2:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [7:0] bus_byte, [8] reinit_needed, [9] ready_res
   logic [1:0]  rsp_tuser;         // [1:0] access
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   char_lcd_bus_sequencer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // sequencer state as predicted
   logic [7:0] busy_tmo;
   logic [4:0] phase;
   logic [7:0] wait_timer;
   logic [5:0] cursor_pos;
   logic [7:0] disp_ctrl;
   logic [9:0] pend [3];
   int         pend_count;
   logic       reinit;

   // polled part of the power-up script, {access, byte}
   logic [9:0] powerup_script [9] = '{
      {ACC_CMD, 8'h38}, {ACC_CMD, 8'h38}, {ACC_CMD, 8'h01}, {ACC_CMD, 8'h06},
      {ACC_CMD, 8'h0C}, {ACC_CMD, 8'h94}, {ACC_DATA, 8'h20}, {ACC_CMD, 8'hD4},
      {ACC_DATA, 8'h20}};

   rsp_entry_type staged [2];
   int            staged_n;
   rsp_entry_type expected_accesses [$];

   int idle_pct = 0;
   int stall_pct = 0;
   int errors = 0;
   int applied_items = 0;
   int dropped_items = 0;
   int checked_results = 0;
   int powerups_done = 0;

   // collect one bus access of the current transaction (at most two)
   function automatic void stage_access(input logic [1:0] acc, input logic [7:0] b);
      if (staged_n < 2) begin
         staged[staged_n].access = acc;
         staged[staged_n].bus_byte = b;
         staged_n++;
      end
   endfunction

   function automatic void begin_poll();
      wait_timer = busy_tmo;
      stage_access(ACC_READ, 8'h00);
   endfunction

   function automatic void queue_write(input logic [1:0] acc, input logic [7:0] b);
      if (pend_count < 3) begin
         pend[pend_count] = {acc, b};
         pend_count++;
      end
   endfunction

   function automatic logic [7:0] ddram_command(input logic [7:0] pos);
      logic [7:0] p;
      p = pos;
      if (p > 8'd15) begin
         p = (p & 8'h2F) | 8'h40;
      end
      return p | 8'h80;
   endfunction

   // issue the write that the finished poll was guarding
   function automatic void complete_poll(input bit timed_out);
      logic [9:0] w;
      if (timed_out) begin
         reinit = 1'b1;
      end
      if (phase >= PH_POLL_FIRST && phase <= PH_POLL_LAST) begin
         w = powerup_script[phase - PH_POLL_FIRST];
         stage_access(w[9:8], w[7:0]);
         if (phase == PH_DC) begin
            disp_ctrl = DC_DEFAULT;
            cursor_pos = '0;
            reinit = 1'b0;
         end
         phase++;
         if (phase > PH_POLL_LAST) begin
            phase = PH_IDLE;
            powerups_done++;
         end else begin
            begin_poll();
         end
      end else if (phase == PH_QUEUE) begin
         w = pend[0];
         stage_access(w[9:8], w[7:0]);
         pend[0] = pend[1];
         pend[1] = pend[2];
         pend[2] = '0;
         if (pend_count > 0) pend_count--;
         if (pend_count > 0) begin
            begin_poll();
         end else begin
            phase = PH_IDLE;
         end
      end
   endfunction

   // advance the predicted state by one transaction and queue its bus accesses
   function automatic bit predict_accesses(input logic [2:0] op, input logic [7:0] val,
                                           input logic [7:0] port);
      bit took = 1'b0;
      staged_n = 0;
      if (op == OP_TICK) begin
         if (phase >= PH_WAIT_FIRST && phase <= PH_WAIT_LAST) begin
            took = 1'b1;
            if (wait_timer <= 8'd1) begin
               stage_access(ACC_CMD, BYTE_WAKE);
               if (phase < PH_WAIT_LAST) begin
                  phase++;
                  wait_timer = (phase == PH_WAIT_MID) ? DELAY_SECOND : DELAY_THIRD;
               end else begin
                  phase = PH_POLL_FIRST;
                  begin_poll();
               end
            end else begin
               wait_timer--;
            end
         end else if (phase != PH_IDLE) begin
            took = 1'b1;
            if (wait_timer <= 8'd1) complete_poll(1'b1);
            else wait_timer--;
         end
      end else if (op == OP_SAMPLE) begin
         if (phase >= PH_POLL_FIRST && phase <= PH_QUEUE) begin
            took = 1'b1;
            if (!port[7]) complete_poll(1'b0);
            else stage_access(ACC_READ, 8'h00);
         end
      end else if (op <= OP_CMODE && phase == PH_IDLE) begin
         took = 1'b1;
         pend_count = 0;
         if (op == OP_INIT) begin
            phase = PH_WAIT_FIRST;
            wait_timer = DELAY_POWERUP;
         end else begin
            case (op)
               OP_CHAR: begin
                  queue_write(ACC_DATA, val);
                  cursor_pos = cursor_pos + 6'd1;
                  queue_write(ACC_CMD, ddram_command({2'b00, cursor_pos}));
                  queue_write(ACC_CMD, disp_ctrl);
               end
               OP_COMMAND: begin
                  queue_write(ACC_CMD, val);
               end
               OP_CURSOR: begin
                  cursor_pos = val[5:0];
                  queue_write(ACC_CMD, ddram_command(val));
                  queue_write(ACC_CMD, disp_ctrl);
               end
               default: begin
                  if (val == 8'd0) disp_ctrl = DC_DEFAULT;
                  else if (val == 8'd2) disp_ctrl = DC_UNDERLINE;
                  else disp_ctrl = DC_BLINK;
                  queue_write(ACC_CMD, disp_ctrl);
               end
            endcase
            phase = PH_QUEUE;
            begin_poll();
         end
      end
      // stamp flags as seen after the transaction
      for (int k = 0; k < staged_n; k++) begin
         staged[k].last = (k == staged_n - 1);
         staged[k].reinit_needed = reinit;
         staged[k].ready_res = (phase == PH_IDLE);
         expected_accesses.push_back(staged[k]);
      end
      return took;
   endfunction

   // drive one request transaction, with random idle cycles ahead of it
   task automatic send_item(input logic [2:0] op, input logic [7:0] val,
                            input logic [7:0] port);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {port, val};
      do @(posedge clock); while (!req_tready);
      if (predict_accesses(op, val, port)) applied_items++;
      else dropped_items++;
   endtask

   // feed ticks and ready status bytes until the sequence is done
   task automatic drain_to_idle();
      while (phase != PH_IDLE) begin
         if (phase <= PH_WAIT_LAST) send_item(OP_TICK, 8'h00, 8'h00);
         else send_item(OP_SAMPLE, 8'h00, 8'h00);
      end
   endtask

   // drop valid and wait for every expected access, with a bound
   task automatic settle_outputs();
      int w;
      @(negedge clock);
      req_tvalid <= 1'b0;
      for (w = 0; w < 4000 && expected_accesses.size() > 0; w++) @(posedge clock);
      if (expected_accesses.size() > 0) begin
         $display("%0t: %0d expected bus accesses never arrived",
                  $time, expected_accesses.size());
         errors++;
      end
      repeat (10) @(posedge clock);
   endtask

   // write busy_timeout; only call with the sequencer idle and settled
   task automatic write_timeout(input logic [7:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      busy_tmo = (v == 8'd0) ? 8'd1 : v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // hold tready low at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // compare each accepted access against the oldest prediction
   always @(posedge clock) begin
      rsp_entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_accesses.size() == 0) begin
            $display("%0t: unexpected access %0d byte %h last %b reinit %b ready %b",
                     $time, rsp_tuser, rsp_tdata[7:0], rsp_tlast, rsp_tdata[8],
                     rsp_tdata[9]);
            errors++;
         end else begin
            want = expected_accesses.pop_front();
            checked_results++;
            if (rsp_tuser !== want.access || rsp_tdata[7:0] !== want.bus_byte ||
                rsp_tlast !== want.last || rsp_tdata[8] !== want.reinit_needed ||
                rsp_tdata[9] !== want.ready_res) begin
               $display("%0t: expected acc %0d byte %h last %b reinit %b ready %b",
                        $time, want.access, want.bus_byte, want.last,
                        want.reinit_needed, want.ready_res);
               $display("%0t:   actual acc %0d byte %h last %b reinit %b ready %b",
                        $time, rsp_tuser, rsp_tdata[7:0], rsp_tlast, rsp_tdata[8],
                        rsp_tdata[9]);
               errors++;
            end
         end
      end
   end

   // ticks, samples and the unused code while nothing waits for them
   task automatic test_stray_items();
      send_item(OP_TICK, 8'h00, 8'h00);
      send_item(OP_SAMPLE, 8'hFF, 8'hFF);
      send_item(OP_UNUSED, 8'hFF, 8'hFF);
      settle_outputs();
   endtask

   // every request kind at its edges, busy status and requests while busy
   task automatic test_requests();
      send_item(OP_CHAR, 8'h00, 8'h00);
      send_item(OP_SAMPLE, 8'h00, 8'h80);
      send_item(OP_INIT, 8'h00, 8'h00);
      send_item(OP_UNUSED, 8'h55, 8'hAA);
      send_item(OP_SAMPLE, 8'h00, 8'h7F);
      drain_to_idle();
      send_item(OP_CHAR, 8'hFF, 8'h00);
      drain_to_idle();
      send_item(OP_COMMAND, 8'hFF, 8'h00);
      drain_to_idle();
      send_item(OP_CURSOR, 8'hFF, 8'h00);
      drain_to_idle();
      send_item(OP_CURSOR, 8'h0F, 8'h00);
      drain_to_idle();
      send_item(OP_CURSOR, 8'h3F, 8'h00);
      drain_to_idle();
      // cursor wraps from the last position back to zero
      send_item(OP_CHAR, 8'h41, 8'h00);
      drain_to_idle();
      for (int m = 0; m < 4; m++) begin
         send_item(OP_CMODE, (m == 3) ? 8'hFF : m[7:0], 8'h00);
         drain_to_idle();
      end
      settle_outputs();
   endtask

   // a zero timeout acts as one tick, so the first tick expires the poll
   task automatic test_timeout();
      write_timeout(8'd0);
      send_item(OP_COMMAND, 8'h01, 8'h00);
      send_item(OP_TICK, 8'h00, 8'h00);
      settle_outputs();
      write_timeout(8'd255);
      send_item(OP_CMODE, 8'd2, 8'h00);
      send_item(OP_TICK, 8'h00, 8'h00);
      drain_to_idle();
      settle_outputs();
   endtask

   // full power-up with timeouts before and after the flag is cleared
   task automatic test_power_up();
      write_timeout(8'd2);
      send_item(OP_INIT, 8'h00, 8'h00);
      while (phase != PH_IDLE) begin
         if (phase <= PH_WAIT_LAST || phase == PH_POLL_FIRST || phase == PH_POLL_LAST)
            send_item(OP_TICK, 8'h00, 8'h00);
         else
            send_item(OP_SAMPLE, 8'h00, 8'h00);
      end
      settle_outputs();
   endtask

   // random requests, each serviced by random ticks and status bytes, plus noise
   task automatic test_random(input int idle, input int stall, input logic [7:0] tmo,
                              input int target);
      int          stop_at;
      int          r;
      logic [2:0]  op;
      logic [7:0]  val;
      idle_pct = idle;
      stall_pct = stall;
      write_timeout(tmo);
      stop_at = applied_items + target;
      while (applied_items < stop_at) begin
         r = $urandom_range(99);
         if (r < 15) begin
            send_item(3'($urandom_range(7)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
         end else begin
            op = (r < 27) ? OP_INIT : 3'($urandom_range(OP_CHAR, OP_CMODE));
            if (op == OP_CMODE && $urandom_range(1)) val = 8'($urandom_range(3));
            else val = 8'($urandom_range(255));
            send_item(op, val, 8'($urandom_range(255)));
            while (phase != PH_IDLE) begin
               r = $urandom_range(99);
               if (r < 8)
                  send_item(3'($urandom_range(7)), 8'($urandom_range(255)),
                            8'($urandom_range(255)));
               else if (phase <= PH_WAIT_LAST || r < 25)
                  send_item(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
               else
                  send_item(OP_SAMPLE, 8'($urandom_range(255)),
                            {1'($urandom_range(99) < 35), 7'($urandom_range(127))});
            end
         end
      end
      settle_outputs();
   endtask

   initial begin
      busy_tmo = TIMEOUT_RESET;
      phase = PH_IDLE;
      wait_timer = '0;
      cursor_pos = '0;
      disp_ctrl = DC_DEFAULT;
      pend = '{default: '0};
      pend_count = 0;
      reinit = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_stray_items();
      test_requests();
      test_timeout();
      test_power_up();
      test_random(0, 0, 8'd1, 140);
      test_random(57, 0, 8'd255, 140);
      test_random(0, 57, 8'($urandom_range(2, 30)), 140);
      test_random(26, 26, 8'd0, 140);

      $display("applied %0d transactions, dropped %0d, checked %0d bus accesses",
               applied_items, dropped_items, checked_results);
      $display("completed %0d power-up sequences across timeouts 0, 1, 2, 255 and random",
               powerups_done);
      if (errors == 0) begin
         $display("char_lcd_bus_sequencer_tb passed");
      end else begin
         $display("char_lcd_bus_sequencer_tb failed");
      end
      $finish;
   end

   // bound the whole run
   initial begin
      #5000000;
      $display("char_lcd_bus_sequencer_tb failed");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/clsq_pkg.sv
hw/rtl/clsq_rsp_fifo.sv
hw/rtl/char_lcd_bus_sequencer.sv
verif/char_lcd_bus_sequencer_tb.sv
